### rtl/sevlog_pkg.sv
// Shared types and constants of the sequenced event ring log.
`default_nettype none

package sevlog_pkg;

  // Field widths of one request and one result.
  localparam int unsigned ClassW = 32;
  localparam int unsigned WordW  = 64;
  localparam int unsigned DataW  = ClassW + 4 * WordW;

  // Request kinds carried in the input tuser bit.
  typedef enum logic {
    OpRecord = 1'b0,
    OpQuery  = 1'b1
  } op_e;

  // One stored event record.
  typedef struct packed {
    logic [ClassW-1:0] class_code;
    logic [WordW-1:0]  actor_key;
    logic [WordW-1:0]  event_time;
    logic [WordW-1:0]  sequence_num;
    logic [WordW-1:0]  generation;
  } record_t;

  // Outcome of a query decided at acceptance.
  typedef struct packed {
    logic valid_res;
    logic gap;
  } qry_flags_t;

  // A query issued toward the result stage.
  typedef struct packed {
    logic       issue;
    qry_flags_t flags;
  } qry_issue_t;

endpackage

`default_nettype wire

### rtl/sevlog_mem.sv
// Record storage: one write port and one registered read port.
`default_nettype none

module sevlog_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [IdxW-1:0]      wr_addr_i,
  input  wire sevlog_pkg::record_t  wr_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [IdxW-1:0]      rd_addr_i,
  output sevlog_pkg::record_t       rd_data_o
);

  sevlog_pkg::record_t mem_q [Depth];
  sevlog_pkg::record_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered data, held between reads.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/sevlog_ctrl.sv
// Ring state, generation register and query decode at request acceptance.
`default_nettype none

module sevlog_ctrl #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned IdxW     = $clog2(Capacity),
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sevlog_pkg::WordW-1:0]  cfg_data_i,
  input  wire logic                          req_i,
  input  wire sevlog_pkg::op_e               op_i,
  input  wire logic [sevlog_pkg::ClassW-1:0] class_code_i,
  input  wire logic [sevlog_pkg::WordW-1:0]  actor_key_i,
  input  wire logic [sevlog_pkg::WordW-1:0]  event_time_i,
  input  wire logic [sevlog_pkg::WordW-1:0]  query_generation_i,
  input  wire logic [sevlog_pkg::WordW-1:0]  query_sequence_i,
  output logic                               wr_en_o,
  output logic [IdxW-1:0]                    wr_addr_o,
  output sevlog_pkg::record_t                wr_data_o,
  output logic [IdxW-1:0]                    rd_addr_o,
  output sevlog_pkg::qry_issue_t             issue_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Capacity - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Capacity);
  localparam logic [CntW:0]   CapExt  = (CntW + 1)'(Capacity);

  logic [sevlog_pkg::WordW-1:0] gen_q, gen_d;
  logic [sevlog_pkg::WordW-1:0] next_seq_q, next_seq_d;
  logic [IdxW-1:0]              head_q, head_d;
  logic [CntW-1:0]              count_q, count_d;

  logic                         is_record, is_query;
  logic [sevlog_pkg::WordW-1:0] oldest, newest, target, seq_off;
  logic [CntW:0]                head_ext, count_ext, tail_ext, sum_ext;
  logic [IdxW-1:0]              tail;
  logic                         pair_zero, gen_match;
  sevlog_pkg::qry_flags_t       flags;

  assign is_record = req_i && (op_i == sevlog_pkg::OpRecord);
  assign is_query  = req_i && (op_i == sevlog_pkg::OpQuery);

  // Stored sequences are consecutive, so the oldest follows from the counter.
  assign oldest  = next_seq_q - sevlog_pkg::WordW'(count_q);
  assign newest  = next_seq_q - 64'd1;
  assign target  = query_sequence_i + 64'd1;
  assign seq_off = target - oldest;

  // Tail slot of the ring, and the slot of the requested record.
  assign head_ext  = (CntW + 1)'(head_q);
  assign count_ext = (CntW + 1)'(count_q);
  always_comb begin
    if (head_ext >= count_ext) begin
      tail_ext = head_ext - count_ext;
    end else begin
      tail_ext = head_ext + CapExt - count_ext;
    end
    tail = tail_ext[IdxW-1:0];
    sum_ext = (CntW + 1)'(tail) + (CntW + 1)'(seq_off[CntW-1:0]);
    if (sum_ext >= CapExt) begin
      sum_ext = sum_ext - CapExt;
    end
  end

  assign pair_zero = (query_generation_i == '0) && (query_sequence_i == '0);
  assign gen_match = (query_generation_i == gen_q) && !pair_zero;

  // Query decision: which slot to read and how to flag the result.
  always_comb begin
    flags     = '0;
    rd_addr_o = tail;
    if (count_q != '0) begin
      if (gen_match) begin
        if (target > newest) begin
          flags = '0;
        end else if (target < oldest) begin
          flags.valid_res = 1'b1;
          flags.gap       = 1'b1;
        end else begin
          flags.valid_res = 1'b1;
          rd_addr_o       = sum_ext[IdxW-1:0];
        end
      end else begin
        flags.valid_res = 1'b1;
        flags.gap       = !pair_zero;
      end
    end
  end

  assign issue_o.issue = is_query;
  assign issue_o.flags = flags;

  // Record write at the head.
  assign wr_en_o                = is_record;
  assign wr_addr_o              = head_q;
  assign wr_data_o.generation   = gen_q;
  assign wr_data_o.sequence_num = next_seq_q;
  assign wr_data_o.event_time   = event_time_i;
  assign wr_data_o.actor_key    = actor_key_i;
  assign wr_data_o.class_code   = class_code_i;

  // Next ring state.
  always_comb begin
    gen_d      = cfg_we_i ? cfg_data_i : gen_q;
    next_seq_d = next_seq_q;
    head_d     = head_q;
    count_d    = count_q;
    if (is_record) begin
      next_seq_d = next_seq_q + 64'd1;
      head_d     = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
      if (count_q != FullCnt) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q      <= 64'd1;
      next_seq_q <= 64'd1;
      head_q     <= '0;
      count_q    <= '0;
    end else begin
      gen_q      <= gen_d;
      next_seq_q <= next_seq_d;
      head_q     <= head_d;
      count_q    <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sevlog_out.sv
// Query stage behind the memory read and the registered result output.
`default_nettype none

module sevlog_out (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sevlog_pkg::qry_issue_t       issue_i,
  input  wire sevlog_pkg::record_t          rd_data_i,
  output logic                              in_ready_o,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [sevlog_pkg::DataW-1:0]      m_axis_tdata,
  output logic [1:0]                        m_axis_tuser
);

  logic                          s1_valid_q, s1_valid_d;
  sevlog_pkg::qry_flags_t        s1_flags_q;
  logic                          s1_adv;
  logic                          out_valid_q, out_valid_d;
  logic [sevlog_pkg::DataW-1:0]  out_data_q, out_data_d;
  logic [1:0]                    out_user_q, out_user_d;

  // The query stage moves on when the output register is free or being taken.
  assign s1_adv     = !out_valid_q || m_axis_tready;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (issue_i.issue) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Result formatting; fields are zero when no record is returned.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
      out_user_d  = {s1_flags_q.gap, s1_flags_q.valid_res};
      if (s1_flags_q.valid_res) begin
        out_data_d = {rd_data_i.class_code, rd_data_i.actor_key, rd_data_i.event_time,
                      rd_data_i.sequence_num, rd_data_i.generation};
      end else begin
        out_data_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (issue_i.issue) begin
      s1_flags_q <= issue_i.flags;
    end
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

### rtl/sequenced_event_ring_log_unit.sv
// Top level of the sequenced event ring log.
//
//  Channel   Direction  Handshake                      Content
//  s_axis    in         s_axis_tvalid/s_axis_tready    record or query request
//  m_axis    out        m_axis_tvalid/m_axis_tready    query result
//  cfg       in         cfg_valid_i/cfg_ready_o        log generation register
//
// One request is accepted per cycle while s_axis_tready is high. The acceptance
// edge of a query registers the memory read; the output register loads it once
// free or being taken. Records give no result and update head, count and
// sequence at once. Reset returns head, count, sequence and generation to their
// initial values; the record memory is not cleared, since unwritten entries
// never reach a result. s_axis_tready drops only while a query waits behind a
// stalled output register.
`default_nettype none

module sequenced_event_ring_log_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write channel.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sevlog_pkg::WordW-1:0] cfg_wdata_i,
  // Request stream.
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: class_code[31:0], actor_key[95:32], event_time[159:96],
  //        query_generation[223:160], query_sequence[287:224]
  input  wire logic [sevlog_pkg::DataW-1:0] s_axis_tdata,
  // tuser: opcode[0]
  input  wire logic                         s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // tdata: out_generation[63:0], out_sequence[127:64], out_time[191:128],
  //        out_actor_key[255:192], out_event_class[287:256]
  output logic [sevlog_pkg::DataW-1:0]      m_axis_tdata,
  // tuser: valid_res[0], gap[1]
  output logic [1:0]                        m_axis_tuser
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                   req;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr, rd_addr;
  sevlog_pkg::record_t    wr_data, rd_data;
  sevlog_pkg::qry_issue_t issue;
  sevlog_pkg::op_e        op;

  assign cfg_ready_o = 1'b1;
  assign req         = s_axis_tvalid && s_axis_tready;
  assign op          = sevlog_pkg::op_e'(s_axis_tuser);

  sevlog_ctrl #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i),
    .cfg_data_i         (cfg_wdata_i),
    .req_i              (req),
    .op_i               (op),
    .class_code_i       (s_axis_tdata[31:0]),
    .actor_key_i        (s_axis_tdata[95:32]),
    .event_time_i       (s_axis_tdata[159:96]),
    .query_generation_i (s_axis_tdata[223:160]),
    .query_sequence_i   (s_axis_tdata[287:224]),
    .wr_en_o            (wr_en),
    .wr_addr_o          (wr_addr),
    .wr_data_o          (wr_data),
    .rd_addr_o          (rd_addr),
    .issue_o            (issue)
  );

  sevlog_mem #(
    .Depth (CAPACITY),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (issue.issue),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sevlog_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .rd_data_i     (rd_data),
    .in_ready_o    (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
